// ===== hw/rtl/ecv_pkg.sv =====
// Shared types and constants for the elastic collision velocity pipeline.
package ecv_pkg;

    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned NUM_LANES  = 2 * NUM_AXES;
    localparam int unsigned QBITS      = 32;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic [31:0]             ma;
        logic [31:0]             mb;
        logic [31:0]             diff;
        logic                    gt;
        logic                    lt;
        logic                    zero;
        logic [2:0][31:0]        maga;
        logic [2:0][31:0]        magb;
        logic [2:0]              nega;
        logic [2:0]              negb;
        logic [2:0][31:0]        va;
        logic [2:0][31:0]        vb;
    } s1_t;

    typedef struct packed {
        logic [2:0][63:0]        pda;
        logic [2:0][63:0]        pdb;
        logic [2:0][63:0]        pma;
        logic [2:0][63:0]        pmb;
        logic                    gt;
        logic                    lt;
        logic                    zero;
        logic [2:0]              nega;
        logic [2:0]              negb;
        logic [2:0][31:0]        va;
        logic [2:0][31:0]        vb;
        logic [32:0]             den;
    } s2_t;

    typedef struct packed {
        logic [64:0]             num;
        logic                    neg;
    } num_t;

    typedef struct packed {
        num_t [5:0]              lane;
        logic [32:0]             den;
        logic                    zero;
    } s3_t;

    typedef struct packed {
        logic [32:0]             rem;
        logic [31:0]             q;
        logic                    neg;
        logic                    over;
    } lane_t;

    typedef struct packed {
        lane_t [5:0]             lane;
        logic [32:0]             den;
        logic                    zero;
    } div_t;

endpackage

// ===== hw/rtl/elastic_collision_velocity_top.sv =====
// Top level: pipelined 3-axis elastic collision velocity update.
//
// Input channel s_*: one transaction carries a body pair (two masses, two
// velocity vectors, unsigned and signed Q16.16). Output channel m_*: one
// transaction carries both new velocity vectors plus zero_mass_sum and
// clipped flags in m_tuser.
// Pipeline: magnitude split, 32x32 products, numerator combine, overflow
// check, 32 restoring divider stages (one quotient bit each, six lanes),
// then saturation into the output register. Throughput is one transaction
// per cycle while the receiver does not stall.
// The divider stage chain sets the latency.
// Reset clears all valid bits; the pipeline is empty afterwards.
// When the receiver stalls with a result pending, every stage holds and
// s_tready drops; nothing is lost or repeated.
// Zero mass sum: velocities pass through unchanged, zero_mass_sum = 1.
module elastic_collision_velocity_top
    import ecv_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mass_a, mass_b, vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_a_x, new_a_y, new_a_z, new_b_x, new_b_y, new_b_z
    output logic [191:0] m_tdata,
    // zero_mass_sum, clipped
    output logic [1:0]   m_tuser
);

    localparam int unsigned NDIV = QBITS;

    logic ce;
    logic out_valid_reg;
    logic [191:0] out_data_reg;
    logic [1:0]   out_user_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;

    logic [NDIV:0] div_valid_reg;
    div_t          div_reg [0:NDIV];
    div_t          div0_next;

    logic [191:0] out_data_next;
    logic [1:0]   out_user_next;

    assign ce       = !out_valid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    function automatic num_t combine(input logic [63:0] t1, input logic s1,
                                     input logic [63:0] p2, input logic s2);
        logic [64:0] a;
        logic [64:0] b;
        num_t        r;
        a = {1'b0, t1};
        b = {p2, 1'b0};
        if (s1 == s2)
        begin
            r.num = a + b;
            r.neg = s1;
        end
        else if (a >= b)
        begin
            r.num = a - b;
            r.neg = s1;
        end
        else
        begin
            r.num = b - a;
            r.neg = s2;
        end
        return r;
    endfunction

    // stage 1: magnitudes and mass difference
    always_comb
    begin
        s1_next.ma   = s_tdata[31:0];
        s1_next.mb   = s_tdata[63:32];
        s1_next.gt   = s1_next.ma > s1_next.mb;
        s1_next.lt   = s1_next.ma < s1_next.mb;
        s1_next.diff = s1_next.lt ? (s1_next.mb - s1_next.ma) : (s1_next.ma - s1_next.mb);
        s1_next.zero = (s1_next.ma == 32'd0) && (s1_next.mb == 32'd0);
        for (int k = 0; k < NUM_AXES; k++)
        begin
            s1_next.va[k]   = s_tdata[64 + 32*k +: 32];
            s1_next.vb[k]   = s_tdata[160 + 32*k +: 32];
            s1_next.nega[k] = s1_next.va[k][31];
            s1_next.negb[k] = s1_next.vb[k][31];
            s1_next.maga[k] = s1_next.nega[k] ? (32'd0 - s1_next.va[k]) : s1_next.va[k];
            s1_next.magb[k] = s1_next.negb[k] ? (32'd0 - s1_next.vb[k]) : s1_next.vb[k];
        end
    end

    // stage 2: products
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            s2_next.pda[k] = {32'd0, s1_reg.diff} * {32'd0, s1_reg.maga[k]};
            s2_next.pdb[k] = {32'd0, s1_reg.diff} * {32'd0, s1_reg.magb[k]};
            s2_next.pma[k] = {32'd0, s1_reg.ma} * {32'd0, s1_reg.maga[k]};
            s2_next.pmb[k] = {32'd0, s1_reg.mb} * {32'd0, s1_reg.magb[k]};
        end
        s2_next.gt   = s1_reg.gt;
        s2_next.lt   = s1_reg.lt;
        s2_next.zero = s1_reg.zero;
        s2_next.nega = s1_reg.nega;
        s2_next.negb = s1_reg.negb;
        s2_next.va   = s1_reg.va;
        s2_next.vb   = s1_reg.vb;
        s2_next.den  = s1_reg.zero ? 33'd1 : ({1'b0, s1_reg.ma} + {1'b0, s1_reg.mb});
    end

    // stage 3: signed numerators; zero mass sum divides raw velocity by one
    always_comb
    begin
        s3_next.den  = s2_reg.den;
        s3_next.zero = s2_reg.zero;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (s2_reg.zero)
            begin
                s3_next.lane[k].num     = {33'd0, s2_reg.va[k]};
                s3_next.lane[k].neg     = 1'b0;
                s3_next.lane[3 + k].num = {33'd0, s2_reg.vb[k]};
                s3_next.lane[3 + k].neg = 1'b0;
            end
            else
            begin
                s3_next.lane[k] = combine(s2_reg.pda[k], s2_reg.lt ^ s2_reg.nega[k],
                                          s2_reg.pmb[k], s2_reg.negb[k]);
                s3_next.lane[3 + k] = combine(s2_reg.pdb[k], s2_reg.gt ^ s2_reg.negb[k],
                                              s2_reg.pma[k], s2_reg.nega[k]);
            end
        end
    end

    // stage 4: overflow check and divider seed
    always_comb
    begin
        div0_next.den  = s3_reg.den;
        div0_next.zero = s3_reg.zero;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            div0_next.lane[l].rem  = s3_reg.lane[l].num[64:32];
            div0_next.lane[l].q    = s3_reg.lane[l].num[31:0];
            div0_next.lane[l].neg  = s3_reg.lane[l].neg;
            div0_next.lane[l].over = s3_reg.lane[l].num[64:32] >= s3_reg.den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            div_valid_reg[0] <= 1'b0;
        end
        else if (ce)
        begin
            s1_valid_reg     <= s_tvalid;
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            div_valid_reg[0] <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s2_next;
            s3_reg     <= s3_next;
            div_reg[0] <= div0_next;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < NDIV; j++)
    begin : g_div
        div_t div_next;

        always_comb
        begin
            logic [33:0] sh;
            div_next = div_reg[j];
            for (int l = 0; l < NUM_LANES; l++)
            begin
                sh = {div_reg[j].lane[l].rem, div_reg[j].lane[l].q[31]};
                if (sh >= {1'b0, div_reg[j].den})
                begin
                    div_next.lane[l].rem = 33'(sh - {1'b0, div_reg[j].den});
                    div_next.lane[l].q   = {div_reg[j].lane[l].q[30:0], 1'b1};
                end
                else
                begin
                    div_next.lane[l].rem = sh[32:0];
                    div_next.lane[l].q   = {div_reg[j].lane[l].q[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                div_valid_reg[j + 1] <= 1'b0;
            else if (ce)
                div_valid_reg[j + 1] <= div_valid_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (ce)
                div_reg[j + 1] <= div_next;
        end
    end

    // saturation and sign restore
    always_comb
    begin
        lane_t ln;
        logic  clip;
        clip = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            ln = div_reg[NDIV].lane[l];
            if (div_reg[NDIV].zero)
                out_data_next[32*l +: 32] = ln.q;
            else if (!ln.neg)
            begin
                if (ln.over || (ln.q > POS_MAX))
                begin
                    out_data_next[32*l +: 32] = POS_MAX;
                    clip = 1'b1;
                end
                else
                    out_data_next[32*l +: 32] = ln.q;
            end
            else
            begin
                if (ln.over || (ln.q > NEG_MIN))
                begin
                    out_data_next[32*l +: 32] = NEG_MIN;
                    clip = 1'b1;
                end
                else
                    out_data_next[32*l +: 32] = 32'd0 - ln.q;
            end
        end
        out_user_next = {clip, div_reg[NDIV].zero};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ce)
            out_valid_reg <= div_valid_reg[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

endmodule

// ===== hw/rtl/ecv_checker.sv =====
// Port-level assertions for the elastic collision velocity top level.
module ecv_checker
    import ecv_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed during stall");

    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline stalled");

    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("clipped with zero mass sum");

endmodule

bind elastic_collision_velocity_top ecv_checker u_ecv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
